// ===== rtl/core/trapezoid_motion_profile_defines.svh =====
// Assertion macros for the trapezoid motion profile block.
`ifndef TRAPEZOID_MOTION_PROFILE_DEFINES_SVH
`define TRAPEZOID_MOTION_PROFILE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("trapezoid profile check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("trapezoid profile check failed");

`endif

// ===== rtl/core/tmp_pkg.sv =====
// Shared constants and types of the trapezoid motion profile block.
`default_nettype none
package tmp_pkg;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL   = 2'd3;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_LOAD,
        CS_MUL,
        CS_PREP,
        CS_DIV1,
        CS_DIV2,
        CS_SQRT
    } t_cstate;
endpackage
`default_nettype wire

// ===== rtl/core/tmp_if.sv =====
// Handshake interfaces for time items, profile items and register writes.
`default_nettype none
interface tmp_in_if #(parameter int DATA_WIDTH = 32) ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] elapsed_time;
    modport source (output valid, output elapsed_time, input ready);
    modport sink (input valid, input elapsed_time, output ready);
endinterface

interface tmp_out_if #(parameter int DATA_WIDTH = 32) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] position_out;
    logic signed [DATA_WIDTH-1:0] velocity_out;
    logic [1:0]                   phase;
    logic                         triangle_flag;
    modport source (output valid, output position_out, output velocity_out,
                    output phase, output triangle_flag, input ready);
    modport sink (input valid, input position_out, input velocity_out,
                  input phase, input triangle_flag, output ready);
endinterface

interface tmp_cfg_if #(parameter int DATA_WIDTH = 32) ();
    import tmp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_WIDTH-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/trapezoid_motion_profile.sv =====
// Trapezoid motion profile: 5-stage profile pipeline, 1 item per cycle unless the solver is busy or the output stalls.
// Phase boundaries come from a bit-serial multiply/divide/sqrt unit that reruns after
// reset and after every register write; input ready is low while it runs.
// Reset (synchronous, active low) restores the register defaults and empties the pipe.
`default_nettype none
module trapezoid_motion_profile #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmp_in_if.sink    i_in,
    tmp_out_if.source o_out,
    tmp_cfg_if.sink   i_cfg
);
    import tmp_pkg::*;
    `include "trapezoid_motion_profile_defines.svh"

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int NW   = W + 2 * F;            // divider numerator width
    localparam int SW   = NW + (NW % 2);        // sqrt input width, even
    localparam int RW   = SW / 2;               // sqrt root width
    localparam int TW   = NW;                   // phase boundary width
    localparam int QW   = (W + 1) / 2 + F + 2;  // clamped quadratic operand
    localparam int LW   = W + F;                // clamped linear operand
    localparam int LH   = LW / 2;
    localparam int OW   = W + 1;                // saturated offset
    localparam int XW   = 2 * QW + W;
    localparam int PW   = W + 3;
    localparam int CNTW = $clog2(NW);

    localparam logic [CNTW-1:0] MUL_LAST = CNTW'(W - 1);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(NW - 1);
    localparam logic [CNTW-1:0] SQ_LAST  = CNTW'(RW - 1);
    localparam logic [TW:0] QLIM = (TW + 1)'({QW{1'b1}});
    localparam logic [TW:0] LCAP = (TW + 1)'({1'b1, {(LW - 1){1'b0}}});
    localparam logic [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};

    function automatic logic [OW-1:0] sat_off(input logic [XW-1:0] x);
        sat_off = (|x[XW-1:OW]) ? {OW{1'b1}} : x[OW-1:0];
    endfunction

    // ---------------- registers ----------------
    logic [W-1:0] r_st, r_en, r_acc, r_vel;
    logic         cfg_wr;
    logic [W-1:0] a_eff, v_eff;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign a_eff       = (r_acc == '0) ? W'(1) : r_acc;
    assign v_eff       = (r_vel == '0) ? W'(1) : r_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_en  <= '0;
            r_acc <= W'(1) << F;
            r_vel <= W'(1) << F;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                REG_START: r_st  <= i_cfg.data;
                REG_END:   r_en  <= i_cfg.data;
                REG_ACCEL: r_acc <= i_cfg.data;
                REG_VEL:   r_vel <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // ---------------- boundary solver ----------------
    t_cstate r_state, n_state;
    logic    busy;
    logic [CNTW-1:0] r_cnt;
    logic            r_up, r_tri;
    logic [W-1:0]    r_d;
    logic [W-1:0]    r_mb_v, r_mb_d;
    logic [2*W-1:0]  r_sh_v, r_sh_a, r_vv, r_da;
    logic [NW-1:0]   r_num, r_quo;
    logic [W-1:0]    r_den, r_rem;
    logic [SW-1:0]   r_sx;
    logic [RW-1:0]   r_srem, r_root;
    logic [TW-1:0]   r_b1, r_b2;
    logic [TW:0]     r_b3;

    logic [W:0]    s_x, e_x, dif;
    logic          up_now;
    logic [W:0]    dv_sh;
    logic          dv_ge;
    logic [W:0]    dv_sub;
    logic [NW-1:0] dv_quo;
    logic [RW+1:0] sq_sh, sq_trial, sq_sub;
    logic          sq_ge;
    logic [RW-1:0] sq_root;

    always_comb begin
        s_x    = {r_st[W-1], r_st};
        e_x    = {r_en[W-1], r_en};
        up_now = $signed(e_x) > $signed(s_x);
        dif    = up_now ? e_x - s_x : s_x - e_x;
        dv_sh  = {r_rem, r_num[NW-1]};
        dv_ge  = dv_sh >= {1'b0, r_den};
        dv_sub = dv_ge ? dv_sh - {1'b0, r_den} : dv_sh;
        dv_quo = {r_quo[NW-2:0], dv_ge};
        sq_sh    = {r_srem, r_sx[SW-1:SW-2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        sq_sub   = sq_ge ? sq_sh - sq_trial : sq_sh;
        sq_root  = {r_root[RW-2:0], sq_ge};
    end

    always_comb begin
        case (r_state)
            CS_IDLE: n_state = CS_IDLE;
            CS_LOAD: n_state = CS_MUL;
            CS_MUL:  n_state = (r_cnt == MUL_LAST) ? CS_PREP : CS_MUL;
            CS_PREP: n_state = CS_DIV1;
            CS_DIV1: n_state = (r_cnt == DIV_LAST) ? (r_tri ? CS_SQRT : CS_DIV2) : CS_DIV1;
            CS_DIV2: n_state = (r_cnt == DIV_LAST) ? CS_IDLE : CS_DIV2;
            CS_SQRT: n_state = (r_cnt == SQ_LAST) ? CS_IDLE : CS_SQRT;
            default: n_state = CS_LOAD;
        endcase
        if (cfg_wr) begin
            n_state = CS_LOAD;
        end
    end

    always_comb begin
        case (r_state)
            CS_IDLE: busy = 1'b0;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_LOAD: begin
                r_up   <= up_now;
                r_d    <= dif[W-1:0];
                r_mb_v <= v_eff;
                r_sh_v <= (2 * W)'(v_eff);
                r_mb_d <= dif[W-1:0];
                r_sh_a <= (2 * W)'(a_eff);
                r_vv   <= '0;
                r_da   <= '0;
                r_cnt  <= '0;
            end
            CS_MUL: begin
                if (r_mb_v[0]) begin
                    r_vv <= r_vv + r_sh_v;
                end
                if (r_mb_d[0]) begin
                    r_da <= r_da + r_sh_a;
                end
                r_mb_v <= r_mb_v >> 1;
                r_mb_d <= r_mb_d >> 1;
                r_sh_v <= r_sh_v << 1;
                r_sh_a <= r_sh_a << 1;
                r_cnt  <= (r_cnt == MUL_LAST) ? '0 : r_cnt + 1'b1;
            end
            CS_PREP: begin
                // triangle when the velocity limit is never reached: V*V >= D*A
                r_tri <= r_vv >= r_da;
                r_num <= (r_vv >= r_da) ? NW'({r_d, {(2 * F){1'b0}}})
                                        : NW'({v_eff, {F{1'b0}}});
                r_den <= a_eff;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            CS_DIV1, CS_DIV2: begin
                r_rem <= dv_sub[W-1:0];
                r_num <= r_num << 1;
                r_quo <= dv_quo;
                r_cnt <= (r_cnt == DIV_LAST) ? '0 : r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    if (r_state == CS_DIV2) begin
                        r_b2 <= dv_quo;
                        r_b3 <= {1'b0, r_b1} + {1'b0, dv_quo};
                    end else if (r_tri) begin
                        r_sx   <= SW'(dv_quo);
                        r_srem <= '0;
                        r_root <= '0;
                    end else begin
                        r_b1  <= dv_quo;
                        r_num <= NW'({r_d, {F{1'b0}}});
                        r_den <= v_eff;
                        r_rem <= '0;
                        r_quo <= '0;
                    end
                end
            end
            CS_SQRT: begin
                r_srem <= sq_sub[RW-1:0];
                r_root <= sq_root;
                r_sx   <= r_sx << 2;
                r_cnt  <= (r_cnt == SQ_LAST) ? '0 : r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    r_b1 <= TW'(sq_root);
                    r_b2 <= TW'(sq_root);
                    r_b3 <= (TW + 1)'(sq_root) << 1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- profile pipeline ----------------
    logic en, in_acc;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    assign en         = !r_v5 || o_out.ready;
    assign i_in.ready = en && !busy;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= in_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: phase select and operand clamp
    logic [W-1:0]  r_tin;
    logic [TW:0]   a_t, a_r, a_q, a_l;
    logic [1:0]    a_ph;
    logic [QW-1:0] a_qc;
    logic [LW-1:0] a_lc;

    always_comb begin
        a_t = (TW + 1)'(r_tin);
        a_r = r_b3 - a_t;
        if (a_t < {1'b0, r_b1}) begin
            a_ph = PH_ACCEL;
        end else if (a_t < {1'b0, r_b2}) begin
            a_ph = PH_CRUISE;
        end else if (a_t <= r_b3) begin
            a_ph = PH_DECEL;
        end else begin
            a_ph = PH_DONE;
        end
        case (a_ph)
            PH_ACCEL: begin
                a_q = a_t;
                a_l = a_t;
            end
            PH_CRUISE: begin
                a_q = {1'b0, r_b1};
                a_l = '0;
            end
            PH_DECEL: begin
                a_q = a_r;
                a_l = a_r;
            end
            default: begin
                a_q = '0;
                a_l = '0;
            end
        endcase
        // beyond these caps the result saturates anyway
        a_qc = (a_q > QLIM) ? {QW{1'b1}} : a_q[QW-1:0];
        a_lc = (a_l > LCAP) ? LCAP[LW-1:0] : a_l[LW-1:0];
    end

    logic [1:0]          r_ph2, r_ph3, r_ph4, r_ph5;
    logic [QW-1:0]       r_q2;
    logic [LW-1:0]       r_l2;
    logic [W-1:0]        r_dt2;
    logic [2*QW-1:0]     r_sq3;
    logic [LH+W-1:0]     r_pla3;
    logic [LW-LH+W-1:0]  r_pha3;
    logic [2*W-1:0]      r_plin3;
    logic [QW+W-1:0]     r_sqalo4, r_sqahi4;
    logic [W-1:0]        r_vm4;
    logic                r_vbig4;
    logic [OW-1:0]       r_lin4;
    logic [W-1:0]        r_pos5, r_vel5;

    logic [LW+W-1:0]     c_vprod;
    logic [2*W-1:0]      c_vmf;
    logic [W-1:0]        c_vm;
    logic                c_vbig;

    always_comb begin
        c_vprod = {r_pha3, {LH{1'b0}}} + (LW + W)'(r_pla3);
        c_vmf   = c_vprod[LW+W-1:F];
        case (r_ph3)
            PH_CRUISE: begin
                c_vm   = v_eff;
                c_vbig = v_eff[W-1];
            end
            PH_DONE: begin
                c_vm   = '0;
                c_vbig = 1'b0;
            end
            default: begin
                c_vm   = c_vmf[W-1:0];
                c_vbig = |c_vmf[2*W-1:W-1];
            end
        endcase
    end

    logic [XW-1:0]         d_sqa;
    logic [OW-1:0]         d_offq, d_off;
    logic [OW:0]           d_sum;
    logic                  d_add, d_end;
    logic signed [PW-1:0]  d_base, d_offx, d_pw;
    logic [W-1:0]          d_pos, d_vel;

    always_comb begin
        d_sqa  = {r_sqahi4, {QW{1'b0}}} + XW'(r_sqalo4);
        d_offq = sat_off(d_sqa >> (2 * F + 1));
        d_sum  = (OW + 1)'(d_offq) + (OW + 1)'(r_lin4);
        case (r_ph4)
            PH_CRUISE: d_off = d_sum[OW] ? {OW{1'b1}} : d_sum[OW-1:0];
            PH_DONE:   d_off = '0;
            default:   d_off = d_offq;
        endcase
        d_end  = (r_ph4 == PH_DECEL) || (r_ph4 == PH_DONE);
        d_base = d_end ? PW'($signed(r_en)) : PW'($signed(r_st));
        d_add  = r_up ^ d_end;
        d_offx = $signed(PW'(d_off));
        d_pw   = d_add ? d_base + d_offx : d_base - d_offx;
        if (d_pw[PW-1] && !(&d_pw[PW-1:W-1])) begin
            d_pos = SMIN;
        end else if (!d_pw[PW-1] && (|d_pw[PW-1:W-1])) begin
            d_pos = SMAX;
        end else begin
            d_pos = d_pw[W-1:0];
        end
        if (r_up) begin
            d_vel = r_vbig4 ? SMAX : r_vm4;
        end else begin
            d_vel = r_vbig4 ? SMIN : (~r_vm4 + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tin    <= i_in.elapsed_time;
            r_ph2    <= a_ph;
            r_q2     <= a_qc;
            r_l2     <= a_lc;
            r_dt2    <= r_tin - r_b1[W-1:0];
            r_ph3    <= r_ph2;
            r_sq3    <= r_q2 * r_q2;
            r_pla3   <= r_l2[LH-1:0] * a_eff;
            r_pha3   <= r_l2[LW-1:LH] * a_eff;
            r_plin3  <= r_dt2 * v_eff;
            r_ph4    <= r_ph3;
            r_sqalo4 <= r_sq3[QW-1:0] * a_eff;
            r_sqahi4 <= r_sq3[2*QW-1:QW] * a_eff;
            r_vm4    <= c_vm;
            r_vbig4  <= c_vbig;
            r_lin4   <= sat_off(XW'(r_plin3 >> F));
            r_ph5    <= r_ph4;
            r_pos5   <= d_pos;
            r_vel5   <= d_vel;
        end
    end

    assign o_out.valid         = r_v5;
    assign o_out.position_out  = r_pos5;
    assign o_out.velocity_out  = r_vel5;
    assign o_out.phase         = r_ph5;
    assign o_out.triangle_flag = r_tri;

    // ---------------- checks ----------------
    `TMP_ASSERT_NXT(a_cfg_busy, i_clk, i_rst_n, cfg_wr, busy)
    `TMP_ASSERT_IMP(a_done_still, i_clk, i_rst_n, o_out.valid && (o_out.phase == PH_DONE), o_out.velocity_out == '0)
    `TMP_ASSERT_IMP(a_tri_nocruise, i_clk, i_rst_n, o_out.valid && (o_out.phase == PH_CRUISE), !o_out.triangle_flag)
endmodule
`default_nettype wire

// ===== dv/tmp_profile_checker.sv =====
// Checker for the trapezoid motion profile: shadows the registers, predicts and compares.
`timescale 1ns / 1ps
module tmp_profile_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tmp_in_if     i_in,
    tmp_out_if    i_out,
    tmp_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);
    import tmp_pkg::*;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic [1:0]         phase;
        logic               triangle;
    } t_profile_point;

    localparam logic [63:0] SAT64   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] OFF_CAP = 64'd1 << 50;

    logic signed [31:0] start_pos, end_pos;
    logic [31:0]        accel_lim, vel_lim;
    t_profile_point     expected_points[$];

    // floor(x*y*z / 2^sh), saturated to 64 bits
    function automatic logic [63:0] prod_shift(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] z, int sh);
        logic [191:0] p;
        p = {128'd0, x} * {128'd0, y};
        p = p * {128'd0, z};
        p = p >> sh;
        if (p[191:64] != 0) return SAT64;
        return p[63:0];
    endfunction

    function automatic logic [63:0] quot_sat(logic [127:0] n, logic [63:0] d);
        logic [127:0] q;
        q = n / {64'd0, d};
        if (q[127:64] != 0) return SAT64;
        return q[63:0];
    endfunction

    function automatic logic [63:0] cap_off(logic [63:0] x);
        return (x > OFF_CAP) ? OFF_CAP : x;
    endfunction

    function automatic t_profile_point profile_at(logic [31:0] t_in);
        t_profile_point     pt;
        logic signed [63:0] s, e, pos;
        logic [63:0]        a, v, t, d, t1, t2, t3, off, vmag, root, cand, r;
        logic [127:0]       q;
        logic               up, tri_move;
        s = start_pos;
        e = end_pos;
        a = (accel_lim == 0) ? 64'd1 : {32'd0, accel_lim};
        v = (vel_lim == 0) ? 64'd1 : {32'd0, vel_lim};
        t = {32'd0, t_in};
        up = e > s;
        d = up ? e - s : s - e;
        tri_move = ({64'd0, v} * {64'd0, v}) >= ({64'd0, d} * {64'd0, a});
        if (tri_move) begin
            q = ({64'd0, d} << 32) / {64'd0, a};
            root = 0;
            for (int i = 63; i >= 0; i--) begin
                cand = root | (64'd1 << i);
                if ({64'd0, cand} * {64'd0, cand} <= q) root = cand;
            end
            t1 = root;
            t2 = root;
        end else begin
            t1 = quot_sat({64'd0, v} << 16, a);
            t2 = quot_sat({64'd0, d} << 16, v);
        end
        t3 = t1 + t2;
        if (t3 < t2) t3 = SAT64;
        if (t < t1) begin
            pt.phase = PH_ACCEL;
            off = cap_off(prod_shift(t, t, a, 33));
            pos = up ? s + off : s - off;
            vmag = prod_shift(t, a, 1, 16);
        end else if (t < t2) begin
            pt.phase = PH_CRUISE;
            off = cap_off(prod_shift(t1, t1, a, 33)) + cap_off(prod_shift(t - t1, v, 1, 16));
            pos = up ? s + off : s - off;
            vmag = v;
        end else if (t <= t3) begin
            pt.phase = PH_DECEL;
            r = t3 - t;
            off = cap_off(prod_shift(r, r, a, 33));
            pos = up ? e - off : e + off;
            vmag = prod_shift(r, a, 1, 16);
        end else begin
            pt.phase = PH_DONE;
            pos = e;
            vmag = 0;
        end
        if (up) pt.velocity = (vmag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : vmag[31:0];
        else pt.velocity = (vmag >= 64'h8000_0000) ? 32'sh8000_0000 : -vmag[31:0];
        if (pos > 64'sh7FFF_FFFF) pt.position = 32'sh7FFF_FFFF;
        else if (pos < -64'sh8000_0000) pt.position = 32'sh8000_0000;
        else pt.position = pos[31:0];
        pt.triangle = tri_move;
        return pt;
    endfunction

    always @(posedge i_clk) begin
        t_profile_point want;
        if (!i_rst_n) begin
            start_pos = 0;
            end_pos   = 0;
            accel_lim = 32'h0001_0000;
            vel_lim   = 32'h0001_0000;
            expected_points.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_START: start_pos = i_cfg.data;
                    REG_END:   end_pos   = i_cfg.data;
                    REG_ACCEL: accel_lim = i_cfg.data;
                    REG_VEL:   vel_lim   = i_cfg.data;
                    default:   ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_points.push_back(profile_at(i_in.elapsed_time));
            if (i_out.valid && i_out.ready) begin
                o_checked <= o_checked + 1;
                if (expected_points.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected item pos=%h vel=%h ph=%0d tri=%0b",
                                 i_out.position_out, i_out.velocity_out,
                                 i_out.phase, i_out.triangle_flag);
                end else begin
                    want = expected_points.pop_front();
                    if (want.position !== i_out.position_out
                            || want.velocity !== i_out.velocity_out
                            || want.phase !== i_out.phase
                            || want.triangle !== i_out.triangle_flag) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display({"ERROR: mismatch exp pos=%h vel=%h ph=%0d tri=%0b",
                                      " got pos=%h vel=%h ph=%0d tri=%0b"},
                                     want.position, want.velocity, want.phase,
                                     want.triangle, i_out.position_out,
                                     i_out.velocity_out, i_out.phase, i_out.triangle_flag);
                    end
                end
            end
        end
        o_pending <= expected_points.size();
    end
endmodule

// ===== dv/trapezoid_motion_profile_tb.sv =====
// Testbench top for the trapezoid motion profile: stimulus, idling and verdict.
`timescale 1ns / 1ps
module trapezoid_motion_profile_tb;
    import tmp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_MOVES  = 19;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, checked;
    int   items_sent = 0;
    int   cycles = 0;
    bit   no_idle = 0;

    tmp_in_if  in_ch ();
    tmp_out_if out_ch ();
    tmp_cfg_if cfg_ch ();

    trapezoid_motion_profile DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tmp_profile_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.elapsed_time = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_START;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random back-pressure plus one long hold-off while items keep coming
    initial begin
        int  hold;
        bit  long_done;
        hold = 0;
        long_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (!long_done && items_sent >= 400) begin
                long_done = 1;
                hold = 400;
                out_ch.ready <= 1'b0;
            end else begin
                hold = idle_len();
                out_ch.ready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // leaves valid high so that writes can follow back to back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_move(logic [31:0] s, logic [31:0] e, logic [31:0] a, logic [31:0] v);
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        write_reg(REG_START, s);
        write_reg(REG_END, e);
        write_reg(REG_ACCEL, a);
        write_reg(REG_VEL, v);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_time(logic [31:0] t);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.elapsed_time <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rnd_position();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic logic [31:0] rnd_limit();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return 1;
        if (r == 2) return $urandom() | 32'h8000_0000;
        return $urandom() >> $urandom_range(4, 24);
    endfunction

    function automatic logic [31:0] rnd_time();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $urandom() >> $urandom_range(8, 31);
    endfunction

    initial begin
        int n;
        logic [31:0] dir_times [9];
        dir_times = '{32'h0, 32'h1_0000, 32'h1_FFFF, 32'h2_0000, 32'h4_0000, 32'h5_0000,
                      32'h7_0000, 32'h7_0001, 32'hFFFF_FFFF};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // trapezoid: t1 = 2.0, t2 = 5.0, t3 = 7.0
        set_move(32'h0, 32'h000A_0000, 32'h0001_0000, 32'h0002_0000);
        foreach (dir_times[i])
            send_time(dir_times[i]);
        end_burst();
        // equal positions
        set_move(32'h0003_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
        send_time(32'h0); send_time(32'h1);
        end_burst();
        // zero limits, negative direction, full span
        set_move(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
        send_time(32'h0); send_time(32'hAAAA_AAAA); send_time(32'h5555_5555);
        end_burst();
        // velocity above the signed range, full positive span, triangle
        set_move(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_time(32'h0); send_time(32'h0000_8000); send_time(32'h0002_0000);
        send_time(32'hFFFF_FFFF);
        end_burst();
        // velocity above the signed range, downward, long accel
        set_move(32'h0, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
        send_time(32'h8000_0000); send_time(32'hFFFF_FFFF); send_time(32'h0001_0000);
        end_burst();

        for (int m = 0; m < RAND_MOVES; m++) begin
            set_move(rnd_position(), rnd_position(), rnd_limit(), rnd_limit());
            no_idle = (m % 4 == 1);
            n = $urandom_range(80, 120);
            repeat (n) send_time(rnd_time());
            end_burst();
        end
        no_idle = 0;

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d time items over %0d register settings; %0d profile points checked.",
                 items_sent, RAND_MOVES + 5, checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
